FILE: hdl/vdi_pkg.sv
// Package with shared constants and types for the vertex deduplication indexer.
package vdi_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int KeyW = 256;
  localparam int IndexW = 10;

  typedef struct packed {
    logic            first;
    logic [KeyW-1:0] key;
  } vdi_item_t;

  typedef struct packed {
    logic [IndexW-1:0] vertex_index;
    logic              is_new;
    logic              overflow;
  } vdi_result_t;
endpackage

FILE: hdl/vdi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vdi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/vdi_front.sv
// Front part: accepts vertices and queues them for the search engine.
module vdi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vdi_pkg::vdi_item_t in_item,
  output logic               q_valid,
  input  logic               q_take,
  output vdi_pkg::vdi_item_t q_item
);
  import vdi_pkg::*;

  vdi_item_t slot [2];
  logic [1:0] fill;
  logic       wptr;
  logic       rptr;
  logic       push;
  logic       pop;

  assign in_stall = fill[1];
  assign push = in_valid && !fill[1];
  assign pop = q_take && (fill != 2'd0);
  assign q_valid = fill != 2'd0;
  assign q_item = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_item;
    end
    if (rst) begin
      fill <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/vdi_back.sv
// Back part: scans the key table one entry a cycle and appends new vertices.
module vdi_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  vdi_pkg::vdi_item_t   q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vdi_pkg::vdi_result_t out_res
);
  import vdi_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]        state;
  logic [CountW-1:0] count;
  logic [CountW-1:0] lim;
  logic [CountW-1:0] probe;
  logic              rd_live;
  logic [AddrW-1:0]  rd_addr;
  logic [KeyW-1:0]   rd_key;
  logic [KeyW-1:0]   key;
  logic              we;
  logic              hit;
  logic [AddrW-1:0]  hit_addr;
  logic [AddrW-1:0]  rd_addr_q;

  // Entries below the count are always written, so no valid bit is kept.
  vdi_ram #(.Width(KeyW), .Depth(TableDepth)) u_keys (
    .clk(clk), .we(we), .waddr(lim[AddrW-1:0]), .wdata(key),
    .raddr(rd_addr), .rdata(rd_key)
  );

  assign rd_addr = probe[AddrW-1:0];
  assign hit = rd_live && (rd_key == key);
  assign hit_addr = rd_addr_q;
  assign q_take = (state == StIdle) && q_valid;
  assign out_valid = state == StHold;
  assign we = (state == StScan) && !hit && !rd_live && (probe >= lim)
              && (lim != CountW'(TableDepth));

  always_ff @(posedge clk) begin
    if (q_take) begin
      key <= q_item.key;
    end
    if (rst) begin
      state <= StIdle;
      count <= '0;
      rd_live <= 1'b0;
    end else begin
      unique case (state)
        StIdle: begin
          if (q_valid) begin
            lim <= q_item.first ? '0 : count;
            probe <= '0;
            rd_live <= 1'b0;
            state <= StScan;
          end
        end
        StScan: begin
          // The read issued last cycle is checked while the next one is issued.
          if (hit) begin
            out_res <= '{vertex_index: IndexW'(hit_addr), is_new: 1'b0, overflow: 1'b0};
            count <= lim;
            rd_live <= 1'b0;
            state <= StHold;
          end else if (probe < lim) begin
            rd_addr_q <= rd_addr;
            rd_live <= 1'b1;
            probe <= probe + 1'b1;
          end else if (!rd_live) begin
            if (lim == CountW'(TableDepth)) begin
              out_res <= '{vertex_index: '0, is_new: 1'b0, overflow: 1'b1};
              count <= lim;
            end else begin
              out_res <= '{vertex_index: IndexW'(lim), is_new: 1'b1, overflow: 1'b0};
              count <= lim + 1'b1;
            end
            state <= StHold;
          end else begin
            rd_live <= 1'b0;
          end
        end
        StHold: begin
          if (!out_stall) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

FILE: hdl/vertex_dedup_indexer.sv
// Top level of the vertex deduplication indexer.
//   channel | direction | fields
//   input   | in        | first_of_mesh, position_*, tex_*, normal_*
//   output  | out       | vertex_index, is_new, overflow
// The back part reads one stored key a cycle from the key RAM and compares it.
// A hit ends the scan at the matching key; a miss reads every stored key, then
// appends the new key, or flags overflow when the table is full.
// Each vertex is registered in the front queue before the back part takes it.
// A two-entry queue takes new vertices while the scan runs.
// Reset (rst, synchronous) empties the queue and sets the count to zero.
// A stalled result holds in its output register until taken.
module vertex_dedup_indexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_of_mesh,
  input  logic [31:0] position_x,
  input  logic [31:0] position_y,
  input  logic [31:0] position_z,
  input  logic [31:0] tex_u,
  input  logic [31:0] tex_v,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  vertex_index,
  output logic        is_new,
  output logic        overflow
);
  import vdi_pkg::*;

  vdi_item_t   in_item;
  vdi_item_t   q_item;
  vdi_result_t res;
  logic        q_valid;
  logic        q_take;

  assign in_item.first = first_of_mesh;
  assign in_item.key = {normal_z, normal_y, normal_x, tex_v, tex_u,
                        position_z, position_y, position_x};

  vdi_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
  );

  vdi_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign vertex_index = res.vertex_index;
  assign is_new = res.is_new;
  assign overflow = res.overflow;
endmodule

FILE: tb/vertex_dedup_indexer_tb.sv
// Self-checking testbench for the vertex deduplication indexer.
module vertex_dedup_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vdi_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first_of_mesh = 1'b0;
  logic [31:0] position_x = '0, position_y = '0, position_z = '0;
  logic [31:0] tex_u = '0, tex_v = '0;
  logic [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [9:0]  vertex_index;
  logic        is_new;
  logic        overflow;

  logic [KeyW-1:0] mesh_keys[$];
  vdi_result_t     pending_results[$];
  int  mismatch_count = 0;
  int  vertices_sent = 0;
  int  results_seen = 0;
  int  overflow_seen = 0;
  int  long_hold = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  vertex_dedup_indexer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lookup-or-insert over the keys of the current mesh, in first-seen order.
  function automatic vdi_result_t lookup_vertex(input logic first, input logic [KeyW-1:0] key);
    vdi_result_t r;
    r = '0;
    if (first) mesh_keys.delete();
    foreach (mesh_keys[k]) begin
      if (mesh_keys[k] === key) begin
        r.vertex_index = k[IndexW-1:0];
        return r;
      end
    end
    if (mesh_keys.size() >= TableDepth) begin
      r.overflow = 1'b1;
    end else begin
      r.vertex_index = IndexW'(mesh_keys.size());
      r.is_new = 1'b1;
      mesh_keys.insert(mesh_keys.size(), key);
    end
    return r;
  endfunction

  task automatic send_vertex(input logic first, input logic [KeyW-1:0] key);
    int gap;
    vdi_result_t want;
    gap = sender_idles ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_of_mesh <= first;
    {position_x, position_y, position_z, tex_u, tex_v, normal_x, normal_y, normal_z} <= key;
    do @(posedge clk); while (in_stall);
    want = lookup_vertex(first, key);
    pending_results.insert(pending_results.size(), want);
    vertices_sent++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Receiver: random hold-offs, or one long hold when a test asks for it.
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold > 0) begin
        w = long_hold;
        long_hold = 0;
      end else begin
        w = receiver_idles ? $urandom_range(0, 14) : 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    vdi_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (overflow) overflow_seen++;
        if (vertex_index !== want.vertex_index)
          report_mismatch("vertex_index", int'(vertex_index), int'(want.vertex_index));
        if (is_new !== want.is_new)
          report_mismatch("is_new", int'(is_new), int'(want.is_new));
        if (overflow !== want.overflow)
          report_mismatch("overflow", int'(overflow), int'(want.overflow));
      end
    end
  end

  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] k;
    for (int i = 0; i < KeyW / 32; i++) k[i*32 +: 32] = $urandom();
    return k;
  endfunction

  task automatic test_directed();
    logic [KeyW-1:0] z, ones, neg_zero, nan_key;
    z = '0;
    ones = '1;
    neg_zero = {32'h8000_0000, 224'h0};
    nan_key = {8{32'h7fc0_0001}};
    send_vertex(1'b1, z);
    send_vertex(1'b0, ones);
    send_vertex(1'b0, z);
    // Negative zero in the top field differs from positive zero.
    send_vertex(1'b0, neg_zero);
    for (int f = 0; f < 8; f++) send_vertex(1'b0, KeyW'(32'h8000_0000) << (32 * f));
    send_vertex(1'b0, nan_key);
    send_vertex(1'b0, nan_key);
    send_vertex(1'b0, ones);
    send_vertex(1'b0, neg_zero);
    // A mesh start on a vertex already stored still restarts at index zero.
    send_vertex(1'b1, nan_key);
    send_vertex(1'b0, z);
    send_vertex(1'b0, nan_key);
    send_vertex(1'b1, nan_key);
  endtask

  task automatic test_backpressure();
    logic [KeyW-1:0] k;
    sender_idles = 1'b0;
    long_hold = 300;
    k = random_key();
    send_vertex(1'b1, k);
    for (int i = 0; i < 20; i++) send_vertex(1'b0, (i % 3 == 0) ? k : random_key());
    sender_idles = 1'b1;
  endtask

  task automatic test_table_full();
    logic [KeyW-1:0] first_key;
    logic [KeyW-1:0] rk;
    rk = random_key();
    first_key = {32'hffff_ffff, rk[223:0]};
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_vertex(1'b1, first_key);
    // The counter in the top word keeps every key of the fill distinct.
    for (int i = 1; i < TableDepth; i++) begin
      rk = random_key();
      send_vertex(1'b0, {32'(i), rk[223:0]});
    end
    for (int i = 0; i < 3; i++) begin
      rk = random_key();
      send_vertex(1'b0, {32'h8000_0000 | 32'(i), rk[223:0]});
    end
    send_vertex(1'b0, first_key);
    send_vertex(1'b0, {32'(TableDepth - 1), mesh_keys[TableDepth - 1][223:0]});
    send_vertex(1'b1, first_key);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_random_meshes(input int count);
    logic [KeyW-1:0] pool[16];
    logic [KeyW-1:0] k;
    int sent, mesh_len, pick;
    sent = 0;
    while (sent < count) begin
      foreach (pool[i]) pool[i] = random_key();
      mesh_len = $urandom_range(1, 40);
      for (int n = 0; n < mesh_len && sent < count; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) k = pool[$urandom_range(0, 15)];
        else if (pick < 85) k = pool[$urandom_range(0, 15)] ^ (KeyW'(1) << $urandom_range(0, KeyW - 1));
        else k = random_key();
        send_vertex(n == 0 || $urandom_range(0, 49) == 0, k);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_table_full();
    test_random_meshes(750);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (1100) @(posedge clk);
    $display("Sent %0d vertices, checked %0d results (%0d overflow).", vertices_sent,
             results_seen, overflow_seen);
    $display("Covered signed zeros, NaN keys, mesh restarts, a full table and backpressure.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
